FILE: hw/rtl/cohort_component_projection_step_top_assert.svh
// Assertion macros for the cohort projection step block.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef COHORT_COMPONENT_PROJECTION_STEP_TOP_ASSERT_SVH
`define COHORT_COMPONENT_PROJECTION_STEP_TOP_ASSERT_SVH
`ifndef SYNTH
`define CCPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CCPS_ASSERT_SAME(label, ante, cons, msg)
`define CCPS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ccps_pkg.sv
// Shared types and constants for the cohort projection step block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package ccps_pkg;

  localparam int COUNT_W  = 39;
  localparam int SURV_W   = 17;
  localparam int FERT_W   = 16;
  localparam int MIG_W    = 40;
  localparam int STEP_W   = 4;
  localparam int SRB_W    = 18;
  localparam int AGE_W    = 11;
  localparam int OUT_W    = 40;

  localparam int EXP_W    = 41;
  localparam int BASE_W   = 42;
  localparam int DTH_W    = 44;
  localparam int END_W    = 48;
  localparam int SUM_W    = 48;
  localparam int SS_W     = 56;
  localparam int BT_W     = 56;
  localparam int FEM_W    = 57;
  localparam int MAL_W    = 58;
  localparam int INF_W    = 60;
  localparam int END0_W   = 64;

  localparam int A_W      = 72;
  localparam int B_W      = 18;
  localparam int CHUNK_W  = 24;
  localparam int PROD_W   = CHUNK_W + 1 + B_W;
  localparam int ACC_W    = A_W + B_W;

  localparam int DIV_W    = 72;
  localparam int DEN_W    = 19;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam logic signed [B_W-1:0] ONE_Q16 = 18'sd65536;

  localparam logic [STEP_W-1:0] STEP_RESET = 4'd5;
  localparam logic [SRB_W-1:0]  SRB_RESET  = 18'd68813;
  localparam logic              MIG_RESET  = 1'b0;

  typedef enum logic [1:0] {
    REG_STEP_LENGTH    = 2'd0,
    REG_SEX_RATIO      = 2'd1,
    REG_MIGRATION_MODE = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_DM  = 3'd0,
    OP_DF  = 3'd1,
    OP_SS  = 3'd2,
    OP_BR  = 3'd3,
    OP_D0M = 3'd4,
    OP_D0F = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_CAPTURE  = 4'd1,
    CMD_PREP     = 4'd2,
    CMD_MUL      = 4'd3,
    CMD_ROUND    = 4'd4,
    CMD_SUMS     = 4'd5,
    CMD_ROW      = 4'd6,
    CMD_DIV_INIT = 4'd7,
    CMD_DIV_STEP = 4'd8,
    CMD_SIGN     = 4'd9,
    CMD_INFANT   = 4'd10
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    cmd;
    op_e        op;
    logic [1:0] chunk;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [COUNT_W-1:0]      pop_male_start;
    logic [COUNT_W-1:0]      pop_female_start;
    logic [SURV_W-1:0]       survival_male;
    logic [SURV_W-1:0]       survival_female;
    logic [FERT_W-1:0]       fertility_rate;
    logic signed [MIG_W-1:0] migrants_male;
    logic signed [MIG_W-1:0] migrants_female;
    logic                    last_group;
  } in_item_t;

  typedef struct packed {
    logic [AGE_W-1:0]        age_years;
    logic [COUNT_W-1:0]      echo_male_start;
    logic [COUNT_W-1:0]      echo_female_start;
    logic signed [OUT_W-1:0] deaths_male;
    logic signed [OUT_W-1:0] deaths_female;
    logic signed [OUT_W-1:0] births_in_group;
    logic [COUNT_W-1:0]      pop_male_end;
    logic [COUNT_W-1:0]      pop_female_end;
    logic                    final_row;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ccps_ctrl.sv
// Sequencing state machine for the cohort projection step block.
// Depends on ccps_pkg; drives the datapath through ctrl_cmd_t.
`default_nettype none

module ccps_ctrl import ccps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_PREP     = 10'b0000000010,
    S_MUL      = 10'b0000000100,
    S_ROUND    = 10'b0000001000,
    S_SUMS     = 10'b0000010000,
    S_ROW      = 10'b0000100000,
    S_DIV_INIT = 10'b0001000000,
    S_DIV      = 10'b0010000000,
    S_SIGN     = 10'b0100000000,
    S_INFANT   = 10'b1000000000
  } state_t;

  state_t           state, state_next;
  op_e              op, op_next;
  logic [1:0]       chunk, chunk_next;
  logic [CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_DM;
      chunk <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      chunk <= chunk_next;
      count <= count_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    chunk_next = chunk;
    count_next = count;
    cmd.cmd    = CMD_NONE;
    cmd.op     = op;
    cmd.chunk  = chunk;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.cmd    = CMD_CAPTURE;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.cmd = CMD_PREP;
        if (status.first) begin
          state_next = S_IDLE;
        end else begin
          op_next    = OP_DM;
          chunk_next = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.cmd = CMD_MUL;
        if (chunk == 2'd2) begin
          state_next = S_ROUND;
        end else begin
          chunk_next = chunk + 2'd1;
        end
      end
      S_ROUND: begin
        cmd.cmd    = CMD_ROUND;
        chunk_next = '0;
        unique case (op)
          OP_DM: begin
            op_next    = OP_DF;
            state_next = S_MUL;
          end
          OP_DF:  state_next = S_SUMS;
          OP_SS: begin
            op_next    = OP_BR;
            state_next = S_MUL;
          end
          OP_BR:  state_next = S_ROW;
          OP_D0M: begin
            op_next    = OP_D0F;
            state_next = S_MUL;
          end
          OP_D0F: state_next = S_INFANT;
          default: state_next = S_IDLE;
        endcase
      end
      S_SUMS: begin
        cmd.cmd = CMD_SUMS;
        if (status.last) begin
          state_next = S_ROW;
        end else begin
          op_next    = OP_SS;
          chunk_next = '0;
          state_next = S_MUL;
        end
      end
      S_ROW: begin
        if (status.out_free) begin
          cmd.cmd    = CMD_ROW;
          state_next = status.last ? S_DIV_INIT : S_IDLE;
        end
      end
      S_DIV_INIT: begin
        cmd.cmd    = CMD_DIV_INIT;
        count_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.cmd = CMD_DIV_STEP;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_SIGN;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      S_SIGN: begin
        cmd.cmd    = CMD_SIGN;
        op_next    = OP_D0M;
        chunk_next = '0;
        state_next = S_MUL;
      end
      S_INFANT: begin
        if (status.out_free) begin
          cmd.cmd    = CMD_INFANT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ccps_datapath.sv
// Datapath of the cohort projection step block: group state, shared
// chunked multiplier, bit-serial divider and output register. Uses ccps_pkg.
`default_nettype none

module ccps_datapath import ccps_pkg::*; #(
  parameter int MAX_GROUPS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             status,
  input  wire in_item_t          item_data,
  input  wire logic [STEP_W-1:0] step_length,
  input  wire logic [SRB_W-1:0]  sex_ratio_birth,
  input  wire logic              migration_mode,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output out_item_t              result_data
);

  localparam int GI_W   = $clog2(MAX_GROUPS);
  localparam int AGEX_W = AGE_W + GI_W + STEP_W;

  localparam logic signed [63:0] S40_MAX   = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] S40_MIN   = -64'sh0000_0080_0000_0000;
  localparam logic signed [63:0] COUNT_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [BT_W:0] BT_MAX = {2'b00, {(BT_W-1){1'b1}}};
  localparam logic signed [BT_W:0] BT_MIN = {2'b11, {(BT_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF16 = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF17 = ACC_W'(65536);

  function automatic logic signed [OUT_W-1:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > S40_MAX) r = S40_MAX;
    else if (v < S40_MIN) r = S40_MIN;
    return r[OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] clamp_count(input logic signed [63:0] v);
    logic [COUNT_W-1:0] r;
    if (v <= 64'sd0) r = '0;
    else if (v > COUNT_MAX) r = '1;
    else r = v[COUNT_W-1:0];
    return r;
  endfunction

  // Current group.
  logic [COUNT_W-1:0]      sm, sf;
  logic [SURV_W-1:0]       svm, svf;
  logic [FERT_W-1:0]       fert;
  logic                    last_r;
  logic signed [EXP_W-1:0] xm, xf;
  logic signed [MIG_W-1:0] lm, lf;
  logic signed [BASE_W-1:0] bm, bf;

  // Projection state.
  logic signed [EXP_W-1:0] prev_m, prev_f;
  logic signed [BT_W-1:0]  birth_total;
  logic [GI_W-1:0]         group_index;
  logic [SURV_W-1:0]       ism, isf;
  logic [COUNT_W-1:0]      istart_m, istart_f;
  logic signed [MIG_W-1:0] ilm, ilf;

  // Results of the multiplier passes and sums.
  logic signed [DTH_W-1:0] dm_r, df_r;
  logic signed [SS_W-1:0]  ss_r, br_r;
  logic signed [INF_W-1:0] d0m_r, d0f_r;
  logic signed [END_W-1:0] em_r, ef_r;
  logic signed [SUM_W-1:0] sumb;

  // Divider and infant split.
  logic [DIV_W-1:0]        num;
  logic [DEN_W-1:0]        rem, den_r;
  logic signed [FEM_W-1:0] fem_r;
  logic signed [MAL_W-1:0] mal_r;

  logic signed [ACC_W-1:0] acc;

  logic                    out_valid_r;
  out_item_t               out_data_r;

  // Combinational helpers.
  logic signed [MIG_W-1:0]   half_m, half_f;
  logic signed [A_W-1:0]     a_sel;
  logic signed [B_W-1:0]     b_sel;
  logic signed [CHUNK_W:0]   a_chunk;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   rnd16, rnd17;
  logic signed [END_W-1:0]   ef_nolate, em_calc, ef_calc;
  logic signed [BT_W:0]      bt_sum;
  logic [BT_W-1:0]           mag;
  logic [DEN_W-1:0]          den;
  logic [DEN_W:0]            trial;
  logic                      q_bit;
  logic [BT_W-1:0]           f_mag;
  logic signed [FEM_W-1:0]   fem_calc;
  logic [AGEX_W-1:0]         age_wide;
  logic signed [END0_W-1:0]  end0m, end0f;
  logic                      out_free;
  logic                      at_max;

  assign half_m = item_data.migrants_male >>> 1;
  assign half_f = item_data.migrants_female >>> 1;

  always_comb begin
    a_sel = '0;
    b_sel = '0;
    unique case (cmd.op)
      OP_DM: begin
        a_sel = A_W'(bm);
        b_sel = ONE_Q16 - $signed({1'b0, svm});
      end
      OP_DF: begin
        a_sel = A_W'(bf);
        b_sel = ONE_Q16 - $signed({1'b0, svf});
      end
      OP_SS: begin
        a_sel = A_W'(sumb);
        b_sel = $signed(B_W'(step_length));
      end
      OP_BR: begin
        a_sel = A_W'(ss_r);
        b_sel = $signed(B_W'(fert));
      end
      OP_D0M: begin
        a_sel = A_W'(mal_r);
        b_sel = ONE_Q16 - $signed({1'b0, ism});
      end
      OP_D0F: begin
        a_sel = A_W'(fem_r);
        b_sel = ONE_Q16 - $signed({1'b0, isf});
      end
      default: ;
    endcase
  end

  // The wide operand is consumed top chunk first; only that chunk is signed.
  always_comb begin
    priority if (cmd.chunk == 2'd0) begin
      a_chunk = {a_sel[A_W-1], a_sel[A_W-1 -: CHUNK_W]};
    end else if (cmd.chunk == 2'd1) begin
      a_chunk = {1'b0, a_sel[2*CHUNK_W-1 -: CHUNK_W]};
    end else begin
      a_chunk = {1'b0, a_sel[CHUNK_W-1:0]};
    end
  end

  assign prod  = a_chunk * b_sel;
  assign rnd16 = (acc + HALF16) >>> 16;
  assign rnd17 = (acc + HALF17) >>> 17;

  assign ef_nolate = END_W'(bf) - END_W'(df_r);
  assign ef_calc   = ef_nolate + END_W'(lf);
  assign em_calc   = END_W'(bm) - END_W'(dm_r) + END_W'(lm);

  assign bt_sum = (BT_W+1)'(birth_total) + (BT_W+1)'(br_r);

  assign mag   = birth_total[BT_W-1] ? BT_W'(-birth_total) : BT_W'(birth_total);
  assign den   = DEN_W'(ONE_Q16) + DEN_W'(sex_ratio_birth);
  assign trial = {rem, num[DIV_W-1]};
  assign q_bit = (trial >= {1'b0, den_r});

  assign f_mag    = num[BT_W-1:0];
  assign fem_calc = birth_total[BT_W-1] ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});

  assign age_wide = AGEX_W'(group_index) * AGEX_W'(step_length);
  assign end0m    = END0_W'(mal_r) - END0_W'(d0m_r) + END0_W'(ilm);
  assign end0f    = END0_W'(fem_r) - END0_W'(d0f_r) + END0_W'(ilf);

  assign at_max   = (group_index == GI_W'(MAX_GROUPS - 1));
  assign out_free = !out_valid_r || !result_stall;

  assign status.first    = (group_index == '0);
  assign status.last     = last_r;
  assign status.out_free = out_free;

  assign result_valid = out_valid_r;
  assign result_data  = out_data_r;

  // Projection state and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_index <= '0;
      birth_total <= '0;
      prev_m      <= '0;
      prev_f      <= '0;
      ism         <= '0;
      isf         <= '0;
      istart_m    <= '0;
      istart_f    <= '0;
      ilm         <= '0;
      ilf         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cmd == CMD_ROW || cmd.cmd == CMD_INFANT) begin
        out_valid_r <= 1'b1;
      end else if (!result_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.cmd)
        CMD_PREP: begin
          if (group_index == '0) begin
            ism         <= svm;
            isf         <= svf;
            istart_m    <= sm;
            istart_f    <= sf;
            ilm         <= lm;
            ilf         <= lf;
            prev_m      <= xm;
            prev_f      <= xf;
            group_index <= GI_W'(1);
          end
        end
        CMD_ROW: begin
          if (!last_r) begin
            if (bt_sum > BT_MAX) birth_total <= BT_MAX[BT_W-1:0];
            else if (bt_sum < BT_MIN) birth_total <= BT_MIN[BT_W-1:0];
            else birth_total <= bt_sum[BT_W-1:0];
            prev_m <= xm;
            prev_f <= xf;
            if (!at_max) group_index <= group_index + GI_W'(1);
          end
        end
        CMD_INFANT: begin
          group_index <= '0;
          birth_total <= '0;
          prev_m      <= '0;
          prev_f      <= '0;
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.cmd)
      CMD_CAPTURE: begin
        sm     <= item_data.pop_male_start;
        sf     <= item_data.pop_female_start;
        svm    <= item_data.survival_male;
        svf    <= item_data.survival_female;
        fert   <= item_data.fertility_rate;
        last_r <= item_data.last_group;
        if (migration_mode) begin
          xm <= $signed(EXP_W'(item_data.pop_male_start));
          xf <= $signed(EXP_W'(item_data.pop_female_start));
          lm <= item_data.migrants_male;
          lf <= item_data.migrants_female;
        end else begin
          xm <= $signed(EXP_W'(item_data.pop_male_start)) + EXP_W'(half_m);
          xf <= $signed(EXP_W'(item_data.pop_female_start)) + EXP_W'(half_f);
          lm <= item_data.migrants_male - half_m;
          lf <= item_data.migrants_female - half_f;
        end
      end
      CMD_PREP: begin
        bm <= BASE_W'(prev_m) + (last_r ? BASE_W'(xm) : '0);
        bf <= BASE_W'(prev_f) + (last_r ? BASE_W'(xf) : '0);
      end
      CMD_MUL: begin
        if (cmd.chunk == 2'd0) acc <= ACC_W'(prod);
        else acc <= (acc <<< CHUNK_W) + ACC_W'(prod);
      end
      CMD_ROUND: begin
        unique case (cmd.op)
          OP_DM:  dm_r  <= rnd16[DTH_W-1:0];
          OP_DF:  df_r  <= rnd16[DTH_W-1:0];
          OP_SS:  ss_r  <= acc[SS_W-1:0];
          OP_BR:  br_r  <= rnd17[SS_W-1:0];
          OP_D0M: d0m_r <= rnd16[INF_W-1:0];
          OP_D0F: d0f_r <= rnd16[INF_W-1:0];
          default: ;
        endcase
      end
      CMD_SUMS: begin
        em_r <= em_calc;
        ef_r <= ef_calc;
        sumb <= SUM_W'(xf) + (migration_mode ? ef_nolate : ef_calc);
      end
      CMD_DIV_INIT: begin
        num   <= {mag, 16'b0} + DIV_W'(den >> 1);
        rem   <= '0;
        den_r <= den;
      end
      CMD_DIV_STEP: begin
        rem <= q_bit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        num <= {num[DIV_W-2:0], q_bit};
      end
      CMD_SIGN: begin
        fem_r <= fem_calc;
        mal_r <= MAL_W'(birth_total) - MAL_W'(fem_calc);
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.cmd == CMD_ROW) begin
      out_data_r.age_years         <= age_wide[AGE_W-1:0];
      out_data_r.echo_male_start   <= sm;
      out_data_r.echo_female_start <= sf;
      out_data_r.deaths_male       <= sat40(64'(dm_r));
      out_data_r.deaths_female     <= sat40(64'(df_r));
      out_data_r.births_in_group   <= last_r ? '0 : sat40(64'(br_r));
      out_data_r.pop_male_end      <= clamp_count(64'(em_r));
      out_data_r.pop_female_end    <= clamp_count(64'(ef_r));
      out_data_r.final_row         <= 1'b0;
    end else if (cmd.cmd == CMD_INFANT) begin
      out_data_r.age_years         <= '0;
      out_data_r.echo_male_start   <= istart_m;
      out_data_r.echo_female_start <= istart_f;
      out_data_r.deaths_male       <= sat40(64'(d0m_r));
      out_data_r.deaths_female     <= sat40(64'(d0f_r));
      out_data_r.births_in_group   <= '0;
      out_data_r.pop_male_end      <= clamp_count(end0m);
      out_data_r.pop_female_end    <= clamp_count(end0f);
      out_data_r.final_row         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cohort_component_projection_step_top.sv
// Cohort projection step, top level: configuration registers, controller, datapath.
// Group 0 is only stored; a middle group yields one row, the last group its own row
// and then the infant row. A new group is taken only once the current one is done.
// Each middle group forms four products on the shared 25x18 multiplier, chunk by chunk;
// the last group spends most of its time in the one-bit-per-cycle divider.
// Reset (rst, synchronous) restores default registers and starts at group 0.
`default_nettype none
`include "cohort_component_projection_step_top_assert.svh"

module cohort_component_projection_step_top import ccps_pkg::*; #(
  parameter int MAX_GROUPS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire in_item_t          item_data,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output out_item_t              result_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [STEP_W-1:0] step_length;
  logic [SRB_W-1:0]  sex_ratio_birth;
  logic              migration_mode;
  reg_idx_e          reg_idx;
  logic              cfg_write;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length     <= STEP_RESET;
      sex_ratio_birth <= SRB_RESET;
      migration_mode  <= MIG_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_STEP_LENGTH:    step_length     <= pwdata[STEP_W-1:0];
        REG_SEX_RATIO:      sex_ratio_birth <= pwdata[SRB_W-1:0];
        REG_MIGRATION_MODE: migration_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_LENGTH:    prdata = DATA_W'(step_length);
      REG_SEX_RATIO:      prdata = DATA_W'(sex_ratio_birth);
      REG_MIGRATION_MODE: prdata = DATA_W'(migration_mode);
      default:            prdata = '0;
    endcase
  end

  ccps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  ccps_datapath #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .item_data       (item_data),
    .step_length     (step_length),
    .sex_ratio_birth (sex_ratio_birth),
    .migration_mode  (migration_mode),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_data     (result_data)
  );

  // An item in flight blocks the next transfer until its work is done.
  `CCPS_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "accepted item did not make the block busy")
  // A row is only written into the output register when it is free.
  `CCPS_ASSERT_SAME(a_row_needs_room, cmd.cmd == CMD_ROW || cmd.cmd == CMD_INFANT, status.out_free, "row loaded over a waiting result")
  // The infant row ends a projection and the block returns to group 0.
  `CCPS_ASSERT_NEXT(a_infant_ends, cmd.cmd == CMD_INFANT, !item_stall && status.first && result_valid, "projection not closed after infant row")

endmodule

`default_nettype wire

FILE: tb/ccps_projection_checker.sv
// Watches the item, result and register ports of the cohort projection step block,
// predicts each projected row and compares it with what the block hands out.
// Depends on ccps_pkg for the transfer types and register indexes.
`timescale 1ns / 1ps

module ccps_projection_checker import ccps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  in_item_t          item_data,
  input  logic              result_valid,
  input  logic              result_stall,
  input  out_item_t         result_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending,
  output int                rows_checked,
  output int                projections_done
);

  localparam longint COUNT_MAX = 64'sd549755813887;
  localparam longint S40_MAX = 64'sd549755813887;
  localparam longint S40_MIN = -64'sd549755813888;
  localparam longint BT_MAX = 64'sd36028797018963967;
  localparam longint ONE = 64'sd65536;

  // Configuration as seen on the register port.
  logic [STEP_W-1:0] step_len;
  logic [SRB_W-1:0]  birth_ratio;
  logic              end_mode;

  // Projection state.
  longint prev_exp_m, prev_exp_f, births_sum;
  longint inf_surv_m, inf_surv_f, inf_start_m, inf_start_f, inf_late_m, inf_late_f;
  int     group_no;

  out_item_t expected_rows[$];

  assign pending = expected_rows.size();

  // round(x * c / 2^k), ties upward; split so the product stays within 64 bits.
  function automatic longint scale_round(longint x, longint c, int k);
    longint hi, lo;
    hi = x >>> k;
    lo = x & ((64'sd1 <<< k) - 1);
    return hi * c + ((lo * c + (64'sd1 <<< (k - 1))) >>> k);
  endfunction

  function automatic longint sat_s40(longint v);
    return v > S40_MAX ? S40_MAX : (v < S40_MIN ? S40_MIN : v);
  endfunction

  function automatic longint clamp_count(longint v);
    return v <= 0 ? 64'sd0 : (v > COUNT_MAX ? COUNT_MAX : v);
  endfunction

  function automatic out_item_t make_row(longint age, longint sm, longint sf, longint dm,
                                         longint df, longint b, longint pm, longint pf,
                                         logic fin);
    out_item_t r;
    longint t;
    r.age_years = age[AGE_W-1:0];
    r.echo_male_start = sm[COUNT_W-1:0];
    r.echo_female_start = sf[COUNT_W-1:0];
    t = sat_s40(dm);
    r.deaths_male = t[OUT_W-1:0];
    t = sat_s40(df);
    r.deaths_female = t[OUT_W-1:0];
    t = sat_s40(b);
    r.births_in_group = t[OUT_W-1:0];
    t = clamp_count(pm);
    r.pop_male_end = t[COUNT_W-1:0];
    t = clamp_count(pf);
    r.pop_female_end = t[COUNT_W-1:0];
    r.final_row = fin;
    return r;
  endfunction

  function automatic void clear_projection();
    prev_exp_m = 0; prev_exp_f = 0; births_sum = 0;
    inf_surv_m = 0; inf_surv_f = 0; inf_start_m = 0; inf_start_f = 0;
    inf_late_m = 0; inf_late_f = 0;
    group_no = 0;
  endfunction

  task automatic project_group(in_item_t it);
    longint sm, sf, svm, svf, fert, mm, mf, xm, xf, lm, lf;
    longint bm, bf, dm, df, em, ef, age, sum, birth;
    longint bt, fem, mal, d0m, d0f;
    longint unsigned den, mag, q, r, f;
    sm = longint'(it.pop_male_start);
    sf = longint'(it.pop_female_start);
    svm = longint'(it.survival_male);
    svf = longint'(it.survival_female);
    fert = longint'(it.fertility_rate);
    mm = longint'(it.migrants_male);
    mf = longint'(it.migrants_female);
    if (end_mode) begin
      xm = sm; xf = sf; lm = mm; lf = mf;
    end else begin
      xm = sm + (mm >>> 1); lm = mm - (mm >>> 1);
      xf = sf + (mf >>> 1); lf = mf - (mf >>> 1);
    end
    if (group_no == 0) begin
      inf_surv_m = svm; inf_surv_f = svf;
      inf_start_m = sm; inf_start_f = sf;
      inf_late_m = lm; inf_late_f = lf;
      prev_exp_m = xm; prev_exp_f = xf;
      group_no = 1;
      return;
    end
    bm = prev_exp_m;
    bf = prev_exp_f;
    if (it.last_group) begin
      bm += xm;
      bf += xf;
    end
    dm = scale_round(bm, ONE - svm, 16);
    df = scale_round(bf, ONE - svf, 16);
    em = bm - dm + lm;
    ef = bf - df + lf;
    age = longint'(group_no) * longint'(step_len);
    if (!it.last_group) begin
      // In end mode the births use the end count before migrants arrive.
      sum = (xf + (end_mode ? ef - lf : ef)) * longint'(step_len);
      birth = scale_round(sum, fert, 17);
      births_sum += birth;
      if (births_sum > BT_MAX) births_sum = BT_MAX;
      if (births_sum < -BT_MAX - 1) births_sum = -BT_MAX - 1;
      expected_rows.push_back(make_row(age, sm, sf, dm, df, birth, em, ef, 1'b0));
      prev_exp_m = xm;
      prev_exp_f = xf;
      if (group_no < 127) group_no++;
      return;
    end
    expected_rows.push_back(make_row(age, sm, sf, dm, df, 0, em, ef, 1'b0));
    // Infant row: split the summed births by the sex ratio, females rounded half away.
    bt = births_sum;
    den = 64'd65536 + longint'(birth_ratio);
    mag = bt < 0 ? 64'd0 - longint'(bt) : longint'(bt);
    q = mag / den;
    r = mag % den;
    f = q * 64'd65536 + (r * 64'd65536 + den / 2) / den;
    fem = bt < 0 ? -longint'(f) : longint'(f);
    mal = bt - fem;
    d0m = scale_round(mal, ONE - inf_surv_m, 16);
    d0f = scale_round(fem, ONE - inf_surv_f, 16);
    expected_rows.push_back(make_row(0, inf_start_m, inf_start_f, d0m, d0f, 0,
                                     mal - d0m + inf_late_m, fem - d0f + inf_late_f, 1'b1));
    clear_projection();
    projections_done++;
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: row %0d field %s got %0h expected %0h", $time, rows_checked, field,
             got, want);
    errors++;
  endtask

  task automatic check_row(out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      $display("%0t: unexpected result transfer, nothing outstanding", $time);
      errors++;
      return;
    end
    want = expected_rows.pop_front();
    if (got.age_years !== want.age_years)
      report_mismatch("age_years", got.age_years, want.age_years);
    if (got.echo_male_start !== want.echo_male_start)
      report_mismatch("echo_male_start", got.echo_male_start, want.echo_male_start);
    if (got.echo_female_start !== want.echo_female_start)
      report_mismatch("echo_female_start", got.echo_female_start, want.echo_female_start);
    if (got.deaths_male !== want.deaths_male)
      report_mismatch("deaths_male", got.deaths_male, want.deaths_male);
    if (got.deaths_female !== want.deaths_female)
      report_mismatch("deaths_female", got.deaths_female, want.deaths_female);
    if (got.births_in_group !== want.births_in_group)
      report_mismatch("births_in_group", got.births_in_group, want.births_in_group);
    if (got.pop_male_end !== want.pop_male_end)
      report_mismatch("pop_male_end", got.pop_male_end, want.pop_male_end);
    if (got.pop_female_end !== want.pop_female_end)
      report_mismatch("pop_female_end", got.pop_female_end, want.pop_female_end);
    if (got.final_row !== want.final_row)
      report_mismatch("final_row", got.final_row, want.final_row);
    rows_checked++;
  endtask

  initial begin
    errors = 0;
    rows_checked = 0;
    projections_done = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      step_len <= STEP_RESET;
      birth_ratio <= SRB_RESET;
      end_mode <= MIG_RESET;
      clear_projection();
      expected_rows.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_STEP_LENGTH: step_len <= pwdata[STEP_W-1:0];
          REG_SEX_RATIO: birth_ratio <= pwdata[SRB_W-1:0];
          REG_MIGRATION_MODE: end_mode <= pwdata[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) project_group(item_data);
      if (result_valid && !result_stall) check_row(result_data);
    end
  end

endmodule

FILE: tb/testbench.sv
// Stimulus and verdict for the cohort projection step block: directed and random
// projections under varying idling and register settings. Uses ccps_pkg and the checker.
`timescale 1ns / 1ps

module testbench;
  import ccps_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  in_item_t          item_data = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  out_item_t         result_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int errors, pending, rows_checked, projections_done;
  int send_idle = 0;
  int recv_idle = 0;
  int groups_sent = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  cohort_component_projection_step_top uut (
    .clk, .rst, .item_valid, .item_stall, .item_data, .result_valid, .result_stall,
    .result_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ccps_projection_checker checker_i (
    .clk, .rst, .item_valid, .item_stall, .item_data, .result_valid, .result_stall,
    .result_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .rows_checked, .projections_done
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (hold_request && !hold_done && hold_left == 0) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [COUNT_W-1:0] rand_count();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return COUNT_W'($urandom_range(0, 1 << 20));
      default: return COUNT_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [MIG_W-1:0] rand_migrants();
    case ($urandom_range(9))
      0: return {1'b1, {(MIG_W-1){1'b0}}};
      1: return {1'b0, {(MIG_W-1){1'b1}}};
      2, 3, 4: return MIG_W'(longint'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return MIG_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [SURV_W-1:0] rand_survival();
    case ($urandom_range(9))
      0: return SURV_W'($urandom_range(0, 131071));
      1: return SURV_W'(65536);
      default: return SURV_W'($urandom_range(45000, 65536));
    endcase
  endfunction

  function automatic in_item_t rand_group(logic last);
    in_item_t it;
    it.pop_male_start = rand_count();
    it.pop_female_start = rand_count();
    it.survival_male = rand_survival();
    it.survival_female = rand_survival();
    it.fertility_rate = ($urandom_range(3) == 0) ? FERT_W'($urandom) :
                        FERT_W'($urandom_range(0, 8000));
    it.migrants_male = rand_migrants();
    it.migrants_female = rand_migrants();
    it.last_group = last;
    return it;
  endfunction

  function automatic in_item_t group_of(logic [COUNT_W-1:0] pm, logic [COUNT_W-1:0] pf,
                                        logic [SURV_W-1:0] s, logic [FERT_W-1:0] fr,
                                        logic [MIG_W-1:0] mg, logic last);
    in_item_t it;
    it.pop_male_start = pm;
    it.pop_female_start = pf;
    it.survival_male = s;
    it.survival_female = s;
    it.fertility_rate = fr;
    it.migrants_male = mg;
    it.migrants_female = mg;
    it.last_group = last;
    return it;
  endfunction

  // Each call is entered right after a rising edge; valid is only lowered for a gap.
  task automatic send_group(in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    groups_sent++;
  endtask

  task automatic send_projection(int n, logic junk_first_mark);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = rand_group(i == n - 1);
      if (i == 0 && junk_first_mark) it.last_group = 1'b1;
      send_group(it);
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  int step_set[6] = '{1, 10, 3, 15, 0, 7};
  int ratio_set[6] = '{0, 262143, 68813, 1000, 131072, 70000};
  int mode_set[6] = '{0, 1, 1, 0, 1, 0};

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-scale and empty groups, survival above one, two-group projection,
    // a last mark on the first group, and heavy emigration that clamps end counts.
    send_idle = 36;
    recv_idle = 76;
    send_group(group_of('1, '1, SURV_W'(65536), '1, {1'b0, {(MIG_W-1){1'b1}}}, 1'b0));
    send_group(group_of('0, '0, '0, '0, {1'b1, {(MIG_W-1){1'b0}}}, 1'b0));
    send_group(group_of('1, '1, '1, '1, '0, 1'b1));
    send_group(group_of(COUNT_W'(1000), COUNT_W'(2000), SURV_W'(60000), FERT_W'(3000),
                        MIG_W'(-5), 1'b1));
    send_group(group_of(COUNT_W'(777), COUNT_W'(333), SURV_W'(64000), FERT_W'(4000),
                        MIG_W'(7), 1'b1));
    send_group(group_of(COUNT_W'(1 << 30), COUNT_W'(1 << 30), SURV_W'(65000),
                        FERT_W'(5000), MIG_W'(3), 1'b0));
    send_group(group_of(COUNT_W'(1 << 30), COUNT_W'(1 << 31), SURV_W'(62000),
                        FERT_W'(9000), MIG_W'(-(64'sd1 << 36)), 1'b0));
    send_group(group_of(COUNT_W'(12345), COUNT_W'(54321), SURV_W'(0), FERT_W'(65535),
                        MIG_W'(-(64'sd1 << 38)), 1'b0));
    send_group(group_of(COUNT_W'(99), COUNT_W'(101), SURV_W'(131071), FERT_W'(0),
                        MIG_W'(1), 1'b1));

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      reg_write(REG_STEP_LENGTH, DATA_W'(step_set[phase]));
      reg_write(REG_SEX_RATIO, DATA_W'(ratio_set[phase]));
      reg_write(REG_MIGRATION_MODE, DATA_W'(mode_set[phase]));
      send_idle = phase < 2 ? 36 : (phase < 4 ? 76 : 0);
      recv_idle = phase < 2 ? 76 : (phase < 4 ? 36 : 0);
      target = groups_sent + 70;
      if (phase == 1) hold_request <= 1'b1;
      if (phase == 5) send_projection(130, 1'b0);
      while (groups_sent < target) begin
        case ($urandom_range(9))
          0: send_projection(2, 1'b0);
          1: send_projection($urandom_range(3, 6), 1'b1);
          // Broken sequence: last marks fall at random.
          2: for (int i = 0; i < 4; i++) send_group(rand_group($urandom_range(2) == 0));
          default: send_projection($urandom_range(3, 9), 1'b0);
        endcase
        if (phase == 3 && groups_sent > target - 50 && groups_sent < target - 40) begin
          // Pause mid-projection until every row so far has come back.
          send_group(rand_group(1'b0));
          item_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
          send_projection(3, 1'b0);
        end
      end
      send_projection(3, 1'b0);
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d groups in %0d projections, %0d rows checked,", groups_sent,
             projections_done, rows_checked);
    $display("over six register settings and three idling patterns with a long hold-off.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
